/* hdl/linked_list_pool_manager_core_macros.svh */
// Assertion macros shared by the pool manager checker.
`ifndef LINKED_LIST_POOL_MANAGER_CORE_MACROS_SVH
`define LINKED_LIST_POOL_MANAGER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LLPM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pool manager check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LLPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pool manager check failed");

`endif

/* hdl/llpm_pkg.sv */
// Types, constants and codes shared by the linked list pool manager.
`default_nettype none

package llpm_pkg;

   // Pool geometry: one cell index addresses every cell of the pool.
   localparam int CELL_W     = 8;
   localparam int POOL_CELLS = 1 << CELL_W;
   localparam int VALUE_W    = 32;
   localparam int CMD_W      = 3;

   // Cell 0 heads the chain of free cells.
   localparam logic [CELL_W-1:0] CELL_FREE_HEAD = '0;
   localparam logic [CELL_W-1:0] CELL_LAST      = CELL_W'(POOL_CELLS - 1);

   // A walk checks at most one value per pool cell.
   localparam logic [CELL_W-1:0] STEP_LAST = CELL_W'(POOL_CELLS - 1);

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Stream payload widths.
   localparam int REQ_FIELDS_W = VALUE_W + 2 * CELL_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = CELL_W + 2;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   // Command codes as they arrive on the request stream.
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT   = 3'd0,
      CMD_DELETE   = 3'd1,
      CMD_FIND     = 3'd2,
      CMD_IS_EMPTY = 3'd3,
      CMD_IS_LAST  = 3'd4
   } cmd_type;

   // Operation classes handed from the front to the back.
   typedef enum logic [2:0] {
      OP_INSERT,
      OP_DELETE,
      OP_FIND,
      OP_EMPTY,
      OP_LAST,
      OP_NONE
   } op_type;

   // One classified command waiting in the queue.
   typedef struct packed {
      op_type                    op;
      logic signed [VALUE_W-1:0] value;
      logic [CELL_W-1:0]         head;
      logic [CELL_W-1:0]         pos;
   } op_entry_type;

   // One result; the last field sits in the lowest bits.
   typedef struct packed {
      logic              pool_full;
      logic              answer_flag;
      logic [CELL_W-1:0] found_cell;
   } rsp_payload_type;

   // Queue fill status.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // What the front needs to know about the rest of the block.
   typedef struct packed {
      logic q_full;
      logic clearing;
   } back_status_type;

   // Sequencer states of the back part.
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK_FIRST,
      S_WALK,
      S_DEL_READ_FREE,
      S_DEL_LINK,
      S_DEL_FREE,
      S_INS_TAKE,
      S_INS_UNCHAIN,
      S_INS_READ_POS,
      S_INS_LINK,
      S_INS_ATTACH,
      S_QUERY
   } exec_state_type;

endpackage

`default_nettype wire

/* hdl/linked_list_pool_manager_core.sv */
// Top level of the linked list pool manager.
//
// Keeps singly linked lists in a pool of 256 cells; cell 0 heads the free
// chain and the caller picks the header cells. Each request beat yields
// exactly one response beat, in order. After reset the block writes the
// initial free chain and holds req_tready low meanwhile.
// A command goes from the front decoder through a two-entry queue to a
// sequencer that owns the link and value memories, so cost follows memory
// accesses; find and delete walk the list one cell per cycle, at most 256
// cells. The response is registered, and a new command starts only after
// the previous response has been taken.
`default_nettype none

module linked_list_pool_manager_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // req_tuser: cmd [2:0]
   input  wire logic [llpm_pkg::CMD_W-1:0]          req_tuser,
   // req_tdata: item_value [31:0], list_head [39:32], cell_position [47:40]
   input  wire logic [llpm_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // rsp_tdata: found_cell [7:0], answer_flag [8], pool_full [9], zeros above
   output logic [llpm_pkg::RSP_DATA_W-1:0]          rsp_tdata
);

   llpm_pkg::back_status_type   back_status;
   llpm_pkg::queue_status_type  q_status;
   llpm_pkg::op_entry_type      push_entry;
   llpm_pkg::op_entry_type      head_entry;
   llpm_pkg::rsp_payload_type   rsp_payload;
   logic                        push;
   logic                        pop;
   logic                        clearing;

   assign back_status.q_full   = q_status.full;
   assign back_status.clearing = clearing;

   // Front: accept and classify.
   llpm_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .back_status (back_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   // Queue between front and back.
   llpm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   // Back: memories and sequencer.
   llpm_exec u_exec (
      .clock       (clock),
      .reset       (reset),
      .q_entry     (head_entry),
      .q_status    (q_status),
      .q_pop       (pop),
      .clearing    (clearing),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_payload (rsp_payload)
   );

   // Response beat packing.
   assign rsp_tdata = {{llpm_pkg::RSP_PAD_W{1'b0}}, rsp_payload};

endmodule

`default_nettype wire

/* hdl/llpm_front.sv */
// Front part: takes request beats and classifies them into queue entries.
`default_nettype none

module llpm_front (
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // req_tuser: cmd [2:0]
   input  wire logic [llpm_pkg::CMD_W-1:0]             req_tuser,
   // req_tdata: item_value [31:0], list_head [39:32], cell_position [47:40]
   input  wire logic [llpm_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  wire llpm_pkg::back_status_type              back_status,
   output logic                                        push,
   output llpm_pkg::op_entry_type                      push_entry
);

   localparam int HEAD_LO = llpm_pkg::VALUE_W;
   localparam int POS_LO  = llpm_pkg::VALUE_W + llpm_pkg::CELL_W;

   // No beat is taken while the pool is being initialized or the queue is full.
   assign req_tready = !back_status.q_full && !back_status.clearing;
   assign push       = req_tvalid && req_tready;

   // Unpack the fields and map the command code onto an operation class.
   always_comb begin
      push_entry.value = req_tdata[llpm_pkg::VALUE_W-1:0];
      push_entry.head  = req_tdata[HEAD_LO +: llpm_pkg::CELL_W];
      push_entry.pos   = req_tdata[POS_LO +: llpm_pkg::CELL_W];
      unique case (req_tuser)
         llpm_pkg::CMD_INSERT:   push_entry.op = llpm_pkg::OP_INSERT;
         llpm_pkg::CMD_DELETE:   push_entry.op = llpm_pkg::OP_DELETE;
         llpm_pkg::CMD_FIND:     push_entry.op = llpm_pkg::OP_FIND;
         llpm_pkg::CMD_IS_EMPTY: push_entry.op = llpm_pkg::OP_EMPTY;
         llpm_pkg::CMD_IS_LAST:  push_entry.op = llpm_pkg::OP_LAST;
         default:                push_entry.op = llpm_pkg::OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

/* hdl/llpm_queue.sv */
// Short queue of classified commands between the front and the back.
`default_nettype none

module llpm_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire llpm_pkg::op_entry_type     push_entry,
   input  wire logic                       pop,
   output llpm_pkg::op_entry_type          head_entry,
   output llpm_pkg::queue_status_type      status
);

   llpm_pkg::op_entry_type           entries_ff [llpm_pkg::QUEUE_DEPTH];
   logic [llpm_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [llpm_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [llpm_pkg::QCNT_W-1:0]      count_ff, count_in;

   localparam logic [llpm_pkg::QCNT_W-1:0] COUNT_FULL =
      llpm_pkg::QCNT_W'(llpm_pkg::QUEUE_DEPTH);
   localparam logic [llpm_pkg::QPTR_W-1:0] PTR_LAST =
      llpm_pkg::QPTR_W'(llpm_pkg::QUEUE_DEPTH - 1);

   assign status.full  = (count_ff == COUNT_FULL);
   assign status.empty = (count_ff == '0);
   assign head_entry   = entries_ff[rd_ptr_ff];

   // Pointer and fill count updates; pointers wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : llpm_pkg::QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : llpm_pkg::QPTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = llpm_pkg::QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = llpm_pkg::QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* hdl/llpm_exec.sv */
// Back part: the cell memories and the sequencer that carries out each command.
`default_nettype none

module llpm_exec (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire llpm_pkg::op_entry_type      q_entry,
   input  wire llpm_pkg::queue_status_type  q_status,
   output logic                             q_pop,
   output logic                             clearing,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output llpm_pkg::rsp_payload_type        rsp_payload
);

   localparam int CW = llpm_pkg::CELL_W;

   // Cell memories: one write port and one registered read port each.
   logic [CW-1:0]                link_mem  [llpm_pkg::POOL_CELLS];
   logic [llpm_pkg::VALUE_W-1:0] value_mem [llpm_pkg::POOL_CELLS];

   logic [CW-1:0]                rd_addr;
   logic [CW-1:0]                link_rd_ff;
   logic [llpm_pkg::VALUE_W-1:0] value_rd_ff;
   logic                         link_we;
   logic [CW-1:0]                link_wa;
   logic [CW-1:0]                link_wd;
   logic                         value_we;
   logic [CW-1:0]                value_wa;
   logic [llpm_pkg::VALUE_W-1:0] value_wd;

   // Sequencer registers.
   llpm_pkg::exec_state_type     state_ff, state_in;
   llpm_pkg::op_entry_type       op_ff, op_in;
   logic [CW-1:0]                cur_ff, cur_in;
   logic [CW-1:0]                prev_ff, prev_in;
   logic [CW-1:0]                step_ff, step_in;
   logic [CW-1:0]                clr_ff, clr_in;

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   llpm_pkg::rsp_payload_type    rsp_ff, rsp_in;
   logic                         load;

   logic                         value_hit;

   assign clearing    = (state_ff == llpm_pkg::S_CLEAR);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign value_hit   = (value_rd_ff == op_ff.value);

   // Next state, memory accesses and result loading.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cur_in   = cur_ff;
      prev_in  = prev_ff;
      step_in  = step_ff;
      clr_in   = clr_ff;
      rd_addr  = llpm_pkg::CELL_FREE_HEAD;
      link_we  = 1'b0;
      link_wa  = cur_ff;
      link_wd  = link_rd_ff;
      value_we = 1'b0;
      value_wa = cur_ff;
      value_wd = op_ff.value;
      q_pop    = 1'b0;
      load     = 1'b0;
      rsp_in   = '0;

      unique case (state_ff)
         // Initialization pass: cell i links to i+1, the last cell wraps to 0.
         llpm_pkg::S_CLEAR: begin
            link_we  = 1'b1;
            link_wa  = clr_ff;
            link_wd  = CW'(clr_ff + 1'b1);
            value_we = 1'b1;
            value_wa = clr_ff;
            value_wd = '0;
            clr_in   = CW'(clr_ff + 1'b1);
            if (clr_ff == llpm_pkg::CELL_LAST) begin
               state_in = llpm_pkg::S_IDLE;
            end
         end

         // Take the next command once the result register is free.
         llpm_pkg::S_IDLE: begin
            if (!q_status.empty && !rsp_valid_ff) begin
               q_pop = 1'b1;
               op_in = q_entry;
               unique case (q_entry.op)
                  llpm_pkg::OP_INSERT: begin
                     rd_addr  = llpm_pkg::CELL_FREE_HEAD;
                     state_in = llpm_pkg::S_INS_TAKE;
                  end
                  llpm_pkg::OP_DELETE, llpm_pkg::OP_FIND: begin
                     rd_addr  = q_entry.head;
                     prev_in  = q_entry.head;
                     state_in = llpm_pkg::S_WALK_FIRST;
                  end
                  llpm_pkg::OP_EMPTY: begin
                     rd_addr  = q_entry.head;
                     state_in = llpm_pkg::S_QUERY;
                  end
                  llpm_pkg::OP_LAST: begin
                     rd_addr  = q_entry.pos;
                     state_in = llpm_pkg::S_QUERY;
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end

         // First link of the list; an empty list ends the walk at once.
         llpm_pkg::S_WALK_FIRST: begin
            if (link_rd_ff == '0) begin
               load     = 1'b1;
               state_in = llpm_pkg::S_IDLE;
            end else begin
               cur_in   = link_rd_ff;
               rd_addr  = link_rd_ff;
               step_in  = '0;
               state_in = llpm_pkg::S_WALK;
            end
         end

         // One cell per cycle: compare its value and fetch its successor.
         llpm_pkg::S_WALK: begin
            if (value_hit) begin
               if (op_ff.op == llpm_pkg::OP_FIND) begin
                  load               = 1'b1;
                  rsp_in.found_cell  = cur_ff;
                  state_in           = llpm_pkg::S_IDLE;
               end else begin
                  // Bypass the matching cell.
                  link_we  = 1'b1;
                  link_wa  = prev_ff;
                  link_wd  = link_rd_ff;
                  state_in = llpm_pkg::S_DEL_READ_FREE;
               end
            end else if (step_ff == llpm_pkg::STEP_LAST || link_rd_ff == '0) begin
               // End of list or a runaway walk: not found.
               load     = 1'b1;
               state_in = llpm_pkg::S_IDLE;
            end else begin
               prev_in = cur_ff;
               cur_in  = link_rd_ff;
               rd_addr = link_rd_ff;
               step_in = CW'(step_ff + 1'b1);
            end
         end

         // Delete: read the free chain head after the bypass is written.
         llpm_pkg::S_DEL_READ_FREE: begin
            rd_addr  = llpm_pkg::CELL_FREE_HEAD;
            state_in = llpm_pkg::S_DEL_LINK;
         end

         llpm_pkg::S_DEL_LINK: begin
            link_we  = 1'b1;
            link_wa  = cur_ff;
            link_wd  = link_rd_ff;
            state_in = llpm_pkg::S_DEL_FREE;
         end

         llpm_pkg::S_DEL_FREE: begin
            link_we            = 1'b1;
            link_wa            = llpm_pkg::CELL_FREE_HEAD;
            link_wd            = cur_ff;
            load               = 1'b1;
            rsp_in.answer_flag = 1'b1;
            state_in           = llpm_pkg::S_IDLE;
         end

         // Insert: take the first free cell or report a full pool.
         llpm_pkg::S_INS_TAKE: begin
            if (link_rd_ff == '0) begin
               load             = 1'b1;
               rsp_in.pool_full = 1'b1;
               state_in         = llpm_pkg::S_IDLE;
            end else begin
               cur_in   = link_rd_ff;
               rd_addr  = link_rd_ff;
               state_in = llpm_pkg::S_INS_UNCHAIN;
            end
         end

         llpm_pkg::S_INS_UNCHAIN: begin
            link_we  = 1'b1;
            link_wa  = llpm_pkg::CELL_FREE_HEAD;
            link_wd  = link_rd_ff;
            value_we = 1'b1;
            value_wa = cur_ff;
            value_wd = op_ff.value;
            state_in = llpm_pkg::S_INS_READ_POS;
         end

         llpm_pkg::S_INS_READ_POS: begin
            rd_addr  = op_ff.pos;
            state_in = llpm_pkg::S_INS_LINK;
         end

         llpm_pkg::S_INS_LINK: begin
            link_we  = 1'b1;
            link_wa  = cur_ff;
            link_wd  = link_rd_ff;
            state_in = llpm_pkg::S_INS_ATTACH;
         end

         llpm_pkg::S_INS_ATTACH: begin
            link_we  = 1'b1;
            link_wa  = op_ff.pos;
            link_wd  = cur_ff;
            load     = 1'b1;
            state_in = llpm_pkg::S_IDLE;
         end

         // Empty and last queries both test one link for zero.
         llpm_pkg::S_QUERY: begin
            load               = 1'b1;
            rsp_in.answer_flag = (link_rd_ff == '0);
            state_in           = llpm_pkg::S_IDLE;
         end

         default: begin
            state_in = llpm_pkg::S_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= llpm_pkg::S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
      step_ff <= step_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Link memory.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_rd_ff <= link_mem[rd_addr];
   end

   // Value memory.
   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[value_wa] <= value_wd;
      end
      value_rd_ff <= value_mem[rd_addr];
   end

endmodule

`default_nettype wire

/* hdl/llpm_checker.sv */
// Port-level checks for the pool manager and the bind that attaches them.
`default_nettype none

`include "linked_list_pool_manager_core_macros.svh"

module llpm_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [llpm_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   // A stalled response beat keeps its contents.
   `LLPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // The pool is being initialized right after reset, so no beat is taken.
   `LLPM_ASSERT_IMPL(a_init_blocks, clock, reset, $past(reset), !req_tready)

   // A full pool and a set answer flag never come in the same result.
   `LLPM_ASSERT_IMPL(a_flags_exclusive, clock, reset, rsp_tvalid, !(rsp_tdata[9] && rsp_tdata[8]))

   // A found cell comes only from find, which leaves both flags clear.
   `LLPM_ASSERT_IMPL(a_found_alone, clock, reset, rsp_tvalid && rsp_tdata[7:0] != 8'd0, rsp_tdata[9:8] == 2'b00)

   // Padding bits of the response stay zero.
   `LLPM_ASSERT_IMPL(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[15:10] == 6'd0)

endmodule

bind linked_list_pool_manager_core llpm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
